>>> rtl/rtp_header_parser_unit_assert.svh
// ----------------------------------------------------------------------------
// RTP header parser assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RTP_HEADER_PARSER_UNIT_ASSERT_SVH
`define RTP_HEADER_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define RHP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define RHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rhp_pkg.sv
// ----------------------------------------------------------------------------
// RTP header parser package
// Status codes, fixed-header constants and the structs passed between units.
// ----------------------------------------------------------------------------
package rhp_pkg;

  localparam logic [1:0] V2        = 2'd2;
  localparam int         FIXED_HDR = 12;
  // Wide enough for 12 + 60 + 4 + 4 * 65535.
  localparam int         HS_W      = 19;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_BUFFER = 2'd1,
    ST_BAD_PACKET = 2'd2,
    ST_TOO_LONG   = 2'd3
  } rhp_status_t;

  // Header fields as they stand after the current word is taken in.
  typedef struct packed {
    logic [7:0]  first_octet;
    logic [7:0]  second_octet;
    logic [15:0] seq;
    logic [31:0] stamp;
    logic [31:0] ssrc;
    logic [15:0] ext_words;
    logic [7:0]  final_octet;
    logic        overlong;
  } hdr_snap_t;

  typedef struct packed {
    rhp_status_t status;
    logic [31:0] ssrc;
    logic [15:0] sequence_number;
    logic [31:0] rtp_time;
    logic        marker_bit;
    logic [6:0]  payload_kind;
    logic [12:0] header_length;
    logic [12:0] payload_length;
    logic [7:0]  padding_length;
  } rhp_result_t;

endpackage

>>> rtl/rhp_capture.sv
// ----------------------------------------------------------------------------
// RTP header parser capture unit
// Holds the per-packet header captures and the byte count.
// ----------------------------------------------------------------------------
module rhp_capture #(
  parameter int MAX_PACKET_BYTES = 4096,
  parameter int LEN_W            = 13
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_i,
  input  logic                 last_i,
  input  logic [7:0]           byte_i,
  output rhp_pkg::hdr_snap_t   snap_o,
  output logic [LEN_W-1:0]     len_o
);
  import rhp_pkg::*;

  hdr_snap_t         snap_r;
  hdr_snap_t         snap_nxt;
  logic [LEN_W-1:0]  pos_r;
  logic [LEN_W-1:0]  pos_nxt;
  logic              below_max;
  logic [HS_W-1:0]   pos_x;
  logic [HS_W-1:0]   ext_at;
  logic              ext_on;

  assign below_max = pos_r < LEN_W'(MAX_PACKET_BYTES);
  assign pos_x     = HS_W'(pos_r);
  assign ext_at    = HS_W'(FIXED_HDR) + HS_W'({snap_r.first_octet[3:0], 2'b00});
  assign ext_on    = (pos_r != '0) && snap_r.first_octet[4];

  always_comb begin
    snap_nxt = snap_r;
    pos_nxt  = pos_r;
    if (below_max) begin
      pos_nxt = pos_r + LEN_W'(1);
      if (pos_x == HS_W'(0)) begin
        snap_nxt.first_octet = byte_i;
      end else if (pos_x == HS_W'(1)) begin
        snap_nxt.second_octet = byte_i;
      end else if (pos_x < HS_W'(4)) begin
        snap_nxt.seq = {snap_r.seq[7:0], byte_i};
      end else if (pos_x < HS_W'(8)) begin
        snap_nxt.stamp = {snap_r.stamp[23:0], byte_i};
      end else if (pos_x < HS_W'(FIXED_HDR)) begin
        snap_nxt.ssrc = {snap_r.ssrc[23:0], byte_i};
      end
      if (ext_on && (pos_x == ext_at + HS_W'(2))) begin
        snap_nxt.ext_words = {byte_i, snap_r.ext_words[7:0]};
      end else if (ext_on && (pos_x == ext_at + HS_W'(3))) begin
        snap_nxt.ext_words = {snap_r.ext_words[15:8], byte_i};
      end
      snap_nxt.final_octet = byte_i;
    end else begin
      snap_nxt.overlong = 1'b1;
    end
  end

  assign snap_o = snap_nxt;
  assign len_o  = pos_nxt;

  // Clear everything once the last word of a packet has been judged.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_r <= '0;
      pos_r  <= '0;
    end else if (step_i) begin
      if (last_i) begin
        snap_r <= '0;
        pos_r  <= '0;
      end else begin
        snap_r <= snap_nxt;
        pos_r  <= pos_nxt;
      end
    end
  end

endmodule

>>> rtl/rhp_check.sv
// ----------------------------------------------------------------------------
// RTP header parser packet check
// Runs the length, version and padding checks and forms the result word.
// ----------------------------------------------------------------------------
module rhp_check #(
  parameter int LEN_W = 13
) (
  input  rhp_pkg::hdr_snap_t   snap_i,
  input  logic [LEN_W-1:0]     len_i,
  output rhp_pkg::rhp_result_t res_o
);
  import rhp_pkg::*;

  logic [HS_W-1:0] len_x;
  logic [HS_W-1:0] hs_base;
  logic [HS_W-1:0] hs_ext_hdr;
  logic [HS_W-1:0] hs_full;
  logic [HS_W-1:0] remain;
  logic [HS_W-1:0] pad_x;
  logic [HS_W-1:0] pay;
  logic            has_ext;
  logic            has_pad;
  rhp_status_t     status;

  assign has_ext    = snap_i.first_octet[4];
  assign has_pad    = snap_i.first_octet[5];
  assign len_x      = HS_W'(len_i);
  assign hs_base    = HS_W'(FIXED_HDR) + HS_W'({snap_i.first_octet[3:0], 2'b00});
  assign hs_ext_hdr = has_ext ? hs_base + HS_W'(4) : hs_base;
  assign hs_full    = has_ext ? hs_ext_hdr + HS_W'({snap_i.ext_words, 2'b00}) : hs_ext_hdr;
  assign remain     = len_x - hs_full;
  assign pad_x      = has_pad ? HS_W'(snap_i.final_octet) : '0;
  assign pay        = remain - pad_x;

  always_comb begin
    if (snap_i.overlong) begin
      status = ST_TOO_LONG;
    end else if (len_x < HS_W'(FIXED_HDR)) begin
      status = ST_BAD_BUFFER;
    end else if (snap_i.first_octet[7:6] != V2) begin
      status = ST_BAD_PACKET;
    end else if (len_x < hs_ext_hdr || len_x < hs_full) begin
      status = ST_BAD_BUFFER;
    end else if (has_pad && (remain == '0 || pad_x == '0 || remain < pad_x)) begin
      status = ST_BAD_PACKET;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    res_o        = '0;
    res_o.status = status;
    if (status == ST_OK) begin
      res_o.ssrc             = snap_i.ssrc;
      res_o.sequence_number  = snap_i.seq;
      res_o.rtp_time         = snap_i.stamp;
      res_o.marker_bit       = snap_i.second_octet[7];
      res_o.payload_kind     = snap_i.second_octet[6:0];
      res_o.header_length    = hs_full[12:0];
      res_o.payload_length   = pay[12:0];
      res_o.padding_length   = pad_x[7:0];
    end
  end

endmodule

>>> rtl/rtp_header_parser_unit.sv
// ----------------------------------------------------------------------------
// RTP fixed-header parser
// Byte-wide RTP header capture and packet check, one result per packet.
// ----------------------------------------------------------------------------
// Feed an RTP packet one byte per word in wire order, with in_is_last set on
// its final byte. The block takes one word every cycle: each word passes an
// input register, updates the header captures and, on the last word, the
// checks fill the output register, which raises out_valid, and a new packet
// can follow with no gap. Only a result held in the output register stalls
// the input, and only when a last word waits behind it. On any error status
// all other result fields are zero; bytes past MAX_PACKET_BYTES only mark the
// packet too long.
module rtp_header_parser_unit #(
  parameter int MAX_PACKET_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_ssrc,
  output logic [15:0] out_sequence_number,
  output logic [31:0] out_rtp_time,
  output logic        out_marker_bit,
  output logic [6:0]  out_payload_kind,
  output logic [12:0] out_header_length,
  output logic [12:0] out_payload_length,
  output logic [7:0]  out_padding_length
);
  import rhp_pkg::*;

  localparam int LEN_W = $clog2(MAX_PACKET_BYTES + 1);

  logic             s1_valid_r;
  logic             s1_last_r;
  logic [7:0]       s1_byte_r;
  logic             s1_go;
  logic             step;
  logic             load;
  logic             out_valid_r;
  logic             out_valid_nxt;
  rhp_result_t      res_r;
  rhp_result_t      res_nxt;
  hdr_snap_t        snap;
  logic [LEN_W-1:0] len;
  logic             out_err;
  logic             out_fields_clear;

  // A last word may only advance when the output register is free.
  assign s1_go    = !s1_last_r || !out_valid_r || out_ready;
  assign step     = s1_valid_r && s1_go;
  assign in_ready = !s1_valid_r || s1_go;
  assign load     = step && s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_is_last;
    end
  end

  rhp_capture #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES),
    .LEN_W(LEN_W)
  ) u_capture (
    .clk   (clk),
    .rst_n (rst_n),
    .step_i(step),
    .last_i(s1_last_r),
    .byte_i(s1_byte_r),
    .snap_o(snap),
    .len_o (len)
  );

  rhp_check #(
    .LEN_W(LEN_W)
  ) u_check (
    .snap_i(snap),
    .len_i (len),
    .res_o (res_nxt)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = res_r.status;
  assign out_ssrc             = res_r.ssrc;
  assign out_sequence_number  = res_r.sequence_number;
  assign out_rtp_time         = res_r.rtp_time;
  assign out_marker_bit       = res_r.marker_bit;
  assign out_payload_kind     = res_r.payload_kind;
  assign out_header_length    = res_r.header_length;
  assign out_payload_length   = res_r.payload_length;
  assign out_padding_length   = res_r.padding_length;

  assign out_err          = out_valid && (out_status != ST_OK);
  assign out_fields_clear = (out_ssrc == 32'd0) && (out_sequence_number == 16'd0) &&
                            (out_rtp_time == 32'd0) && (out_header_length == 13'd0) &&
                            (out_payload_length == 13'd0);

`include "rtp_header_parser_unit_assert.svh"

  `RHP_ASSERT_NOW(a_err_fields_zero, out_err, out_fields_clear, "error result has nonzero fields")
  `RHP_ASSERT_NEXT(a_last_gives_result, load, out_valid, "last word did not produce a result")
  `RHP_ASSERT_NOW(a_no_overwrite, out_valid && !out_ready, !load, "pending result overwritten")
  `RHP_ASSERT_NEXT(a_clear_after_last, load, u_capture.pos_r == '0, "capture state not cleared")

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RTP fixed-header parser testbench
// Streams RTP packets a byte per word into the parser, predicts every result
// and compares it field by field. A table of hand-built packets covers the
// header checks first, then random packets follow, mostly well formed.
// ----------------------------------------------------------------------------
module testbench;
  import rhp_pkg::*;

  localparam int MAX_BYTES = 4096;

  // One hand-built packet: first octet, extension length word, bytes after
  // the header, forced final byte (-1 keeps it random), cut length (0 keeps
  // the whole packet) and, for error rows, the status read off directly.
  typedef struct packed {
    logic [7:0]  b0;
    logic [15:0] ext_len;
    int          body;
    int          last_val;
    int          cut;
    bit          fixed;
    rhp_status_t st;
  } pkt_row_t;

  typedef struct packed {
    bit          fixed;
    rhp_status_t st;
  } known_status_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_is_last;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [31:0] out_ssrc;
  logic [15:0] out_sequence_number;
  logic [31:0] out_rtp_time;
  logic        out_marker_bit;
  logic [6:0]  out_payload_kind;
  logic [12:0] out_header_length;
  logic [12:0] out_payload_length;
  logic [7:0]  out_padding_length;

  bit            in_idle_on;
  bit            out_stall_on;
  int            fail_cnt;
  logic [7:0]    pkt_q[$];
  known_status_t known_status_q[$];
  rhp_result_t   pending_results[$];

  // Header captures of the packet in flight.
  int          rx_count;
  logic [7:0]  rx_b0;
  logic [7:0]  rx_b1;
  logic [15:0] rx_seq;
  logic [31:0] rx_stamp;
  logic [31:0] rx_ssrc;
  logic [15:0] rx_ext;
  logic [7:0]  rx_final;
  logic        rx_over;

  pkt_row_t dir_rows [0:22] = '{
    '{8'h80, 16'd0,     0,    -1,  1,   1'b1, ST_BAD_BUFFER},  // one byte
    '{8'h80, 16'd0,     0,    -1,  11,  1'b1, ST_BAD_BUFFER},  // one short of fixed header
    '{8'h80, 16'd0,     0,    -1,  0,   1'b0, ST_OK},          // bare fixed header
    '{8'h00, 16'd0,     4,    -1,  0,   1'b1, ST_BAD_PACKET},  // version 0
    '{8'h40, 16'd0,     4,    -1,  0,   1'b1, ST_BAD_PACKET},  // version 1
    '{8'hC0, 16'd0,     4,    -1,  0,   1'b1, ST_BAD_PACKET},  // version 3
    '{8'hFF, 16'd0,     0,    -1,  0,   1'b1, ST_BAD_PACKET},  // all flags, version 3
    '{8'h20, 16'd0,     0,    -1,  5,   1'b1, ST_BAD_BUFFER},  // short wins over version
    '{8'h8F, 16'd0,     0,    -1,  0,   1'b0, ST_OK},          // fifteen CSRCs
    '{8'h8F, 16'd0,     0,    -1,  71,  1'b1, ST_BAD_BUFFER},  // CSRC list cut
    '{8'h90, 16'd0,     0,    -1,  15,  1'b1, ST_BAD_BUFFER},  // extension header cut
    '{8'h90, 16'd3,     0,    -1,  24,  1'b1, ST_BAD_BUFFER},  // extension data cut
    '{8'h90, 16'd0,     5,    -1,  0,   1'b0, ST_OK},
    '{8'h9F, 16'd2,     3,    -1,  0,   1'b0, ST_OK},
    '{8'hBF, 16'hFFFF,  0,    -1,  100, 1'b1, ST_BAD_BUFFER},  // huge extension length
    '{8'hA0, 16'd0,     0,    -1,  0,   1'b1, ST_BAD_PACKET},  // padding, empty payload
    '{8'hA0, 16'd0,     4,    0,   0,   1'b1, ST_BAD_PACKET},  // zero pad octet
    '{8'hA0, 16'd0,     4,    5,   0,   1'b1, ST_BAD_PACKET},  // pad beyond payload
    '{8'hA0, 16'd0,     4,    4,   0,   1'b0, ST_OK},          // pad fills payload
    '{8'hA0, 16'd0,     255,  255, 0,   1'b0, ST_OK},          // largest pad
    '{8'hB3, 16'd1,     20,   7,   0,   1'b0, ST_OK},
    '{8'h80, 16'd0,     4084, -1,  0,   1'b0, ST_OK},          // exactly the maximum
    '{8'h80, 16'd0,     4085, -1,  0,   1'b1, ST_TOO_LONG}     // one byte over
  };

  rtp_header_parser_unit #(
    .MAX_PACKET_BYTES(MAX_BYTES)
  ) u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_data_byte         (in_data_byte),
    .in_is_last           (in_is_last),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_ssrc             (out_ssrc),
    .out_sequence_number  (out_sequence_number),
    .out_rtp_time         (out_rtp_time),
    .out_marker_bit       (out_marker_bit),
    .out_payload_kind     (out_payload_kind),
    .out_header_length    (out_header_length),
    .out_payload_length   (out_payload_length),
    .out_padding_length   (out_padding_length)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void clear_capture();
    rx_count = 0;
    rx_b0    = '0;
    rx_b1    = '0;
    rx_seq   = '0;
    rx_stamp = '0;
    rx_ssrc  = '0;
    rx_ext   = '0;
    rx_final = '0;
    rx_over  = 1'b0;
  endfunction

  function automatic void capture_byte(logic [7:0] b);
    int ext_at;
    if (rx_count < MAX_BYTES) begin
      if (rx_count == 0) rx_b0 = b;
      else if (rx_count == 1) rx_b1 = b;
      else if (rx_count < 4) rx_seq = {rx_seq[7:0], b};
      else if (rx_count < 8) rx_stamp = {rx_stamp[23:0], b};
      else if (rx_count < 12) rx_ssrc = {rx_ssrc[23:0], b};
      ext_at = FIXED_HDR + 4 * rx_b0[3:0];
      if (rx_count >= 1 && rx_b0[4]) begin
        if (rx_count == ext_at + 2) rx_ext[15:8] = b;
        else if (rx_count == ext_at + 3) rx_ext[7:0] = b;
      end
      rx_final = b;
      rx_count++;
    end else begin
      rx_over = 1'b1;
    end
  endfunction

  function automatic rhp_result_t judge_packet();
    rhp_result_t r;
    int          hs;
    int          pad;
    r   = '0;
    pad = 0;
    if (rx_over) begin
      r.status = ST_TOO_LONG;
    end else if (rx_count < FIXED_HDR) begin
      r.status = ST_BAD_BUFFER;
    end else if (rx_b0[7:6] != V2) begin
      r.status = ST_BAD_PACKET;
    end else begin
      hs = FIXED_HDR + 4 * rx_b0[3:0] + (rx_b0[4] ? 4 : 0);
      if (rx_b0[4] && rx_count >= hs) hs = hs + 4 * rx_ext;
      if (rx_count < hs) begin
        r.status = ST_BAD_BUFFER;
      end else if (rx_b0[5] && (hs == rx_count || rx_final == 8'd0 ||
                                rx_count - hs < rx_final)) begin
        r.status = ST_BAD_PACKET;
      end else begin
        if (rx_b0[5]) pad = rx_final;
        r.status           = ST_OK;
        r.ssrc             = rx_ssrc;
        r.sequence_number  = rx_seq;
        r.rtp_time         = rx_stamp;
        r.marker_bit       = rx_b1[7];
        r.payload_kind     = rx_b1[6:0];
        r.header_length    = 13'(hs);
        r.payload_length   = 13'(rx_count - hs - pad);
        r.padding_length   = 8'(pad);
      end
    end
    return r;
  endfunction

  // Predict on every accepted word; a last word closes the packet.
  always @(posedge clk) begin : in_mon
    rhp_result_t   r;
    known_status_t k;
    if (rst_n && in_valid && in_ready) begin
      capture_byte(in_data_byte);
      if (in_is_last) begin
        r = judge_packet();
        k = known_status_q.pop_front();
        if (k.fixed) begin
          r        = '0;
          r.status = k.st;
        end
        pending_results.push_back(r);
        clear_capture();
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin : out_mon
    rhp_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, actual status %0d", $time, out_status);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_status);
        check_field("ssrc", want.ssrc, out_ssrc);
        check_field("sequence_number", want.sequence_number, out_sequence_number);
        check_field("rtp_time", want.rtp_time, out_rtp_time);
        check_field("marker_bit", want.marker_bit, out_marker_bit);
        check_field("payload_kind", want.payload_kind, out_payload_kind);
        check_field("header_length", want.header_length, out_header_length);
        check_field("payload_length", want.payload_length, out_payload_length);
        check_field("padding_length", want.padding_length, out_padding_length);
      end
    end
  end

  // Result side: ready in random stretches, with stall bursts when enabled.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_stall_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(0, 15)) @(posedge clk);
    end
  end

  task automatic make_packet(input logic [7:0] b0, input logic [15:0] ext_len,
                             input int body, input int last_val, input int cut);
    pkt_q.delete();
    pkt_q.push_back(b0);
    repeat (11 + 4 * b0[3:0]) pkt_q.push_back(8'($urandom));
    if (b0[4]) begin
      repeat (2) pkt_q.push_back(8'($urandom));
      pkt_q.push_back(ext_len[15:8]);
      pkt_q.push_back(ext_len[7:0]);
      // cap a huge extension; the length check rejects it anyway
      for (int i = 0; i < 4 * ext_len && pkt_q.size() < 600; i++)
        pkt_q.push_back(8'($urandom));
    end
    repeat (body) pkt_q.push_back(8'($urandom));
    if (last_val >= 0) pkt_q[pkt_q.size() - 1] = 8'(last_val);
    if (cut > 0) begin
      while (pkt_q.size() > cut) pkt_q.pop_back();
    end
  endtask

  task automatic make_random_packet();
    int         kind;
    int         cc;
    int         ew;
    int         body;
    int         padv;
    int         cut;
    bit         xf;
    bit         pf;
    logic [7:0] b0;
    kind = $urandom_range(0, 99);
    cc   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
    xf   = $urandom_range(0, 1);
    pf   = $urandom_range(0, 1);
    ew   = $urandom_range(0, 4);
    body = ($urandom_range(0, 29) == 0) ? $urandom_range(200, 600) : $urandom_range(0, 40);
    padv = -1;
    cut  = 0;
    if (pf) begin
      if (body == 0) body = 1;
      padv = $urandom_range(1, (body < 255) ? body : 255);
    end
    b0 = {V2, pf, xf, 4'(cc)};
    if (kind < 70) begin
      make_packet(b0, 16'(ew), body, padv, 0);
    end else if (kind < 76) begin
      make_packet({2'($urandom), b0[5:0]}, 16'(ew), body, padv, 0);
    end else if (kind < 84) begin
      make_packet(b0, 16'(ew), body, padv, 0);
      cut = $urandom_range(1, pkt_q.size());
      while (pkt_q.size() > cut) pkt_q.pop_back();
    end else if (kind < 88) begin
      make_packet(b0 | 8'h20, 16'(ew), body + 1, 0, 0);
    end else if (kind < 92) begin
      body = $urandom_range(1, 40);
      make_packet(b0 | 8'h20, 16'(ew), body, $urandom_range(body + 1, 255), 0);
    end else if (kind < 96) begin
      make_packet(b0 | 8'h10, 16'($urandom), body, padv, 0);
    end else begin
      // noise: random bytes of random length
      pkt_q.delete();
      repeat ($urandom_range(1, 30)) pkt_q.push_back(8'($urandom));
    end
  endtask

  task automatic push_word(input logic [7:0] b, input logic last);
    if (in_idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_is_last   <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_packet(input bit fixed, input rhp_status_t st);
    known_status_t k;
    k.fixed = fixed;
    k.st    = st;
    known_status_q.push_back(k);
    foreach (pkt_q[i]) push_word(pkt_q[i], i == pkt_q.size() - 1);
  endtask

  initial begin : stim
    int n;
    in_valid     <= 1'b0;
    in_data_byte <= '0;
    in_is_last   <= 1'b0;
    rst_n        <= 1'b0;
    fail_cnt     = 0;
    in_idle_on   = 1'b0;
    out_stall_on = 1'b0;
    clear_capture();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      in_idle_on   = $urandom_range(0, 3) != 0;
      out_stall_on = $urandom_range(0, 3) != 0;
      make_packet(dir_rows[i].b0, dir_rows[i].ext_len, dir_rows[i].body,
                  dir_rows[i].last_val, dir_rows[i].cut);
      send_packet(dir_rows[i].fixed, dir_rows[i].st);
    end

    for (n = 0; n < 72; n++) begin
      // no idling on either side over the last packets
      in_idle_on   = (n < 60) && ($urandom_range(0, 3) != 0);
      out_stall_on = (n < 60) && ($urandom_range(0, 3) != 0);
      make_random_packet();
      send_packet(1'b0, ST_OK);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    for (n = 0; n < 2000 && pending_results.size() != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
